>>> rtl/direction_angle_full_circle_core_assert.svh
// ----------------------------------------------------------------------------
// direction angle assertion macros
// shared concurrent assertion forms for the direction angle checker
// ----------------------------------------------------------------------------
`ifndef DIRECTION_ANGLE_FULL_CIRCLE_CORE_ASSERT_SVH
`define DIRECTION_ANGLE_FULL_CIRCLE_CORE_ASSERT_SVH

// property checked only outside reset
`define DAFC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dafc assertion failed");

// property checked at every edge, reset included
`define DAFC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dafc assertion failed");

`endif

>>> rtl/dafc_pkg.sv
// ----------------------------------------------------------------------------
// dafc_pkg
// constants, angle codes and atan table for the direction angle core
// ----------------------------------------------------------------------------
`default_nettype none

package dafc_pkg;

    localparam int DEF_COORD_BITS      = 24;
    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STAGES   = 18;

    // cordic datapath: magnitudes sit below a fixed headroom of the word
    localparam int CORDIC_W    = 64;
    localparam int CORDIC_HEAD = 6;

    // angle accumulator and mapped angle, Q32 radians
    localparam int ANG_W = 36;

    localparam logic [ANG_W-1:0] HALF_PI_Q32       = 36'd6746518852;
    localparam logic [ANG_W-1:0] PI_Q32            = 36'd13493037705;
    localparam logic [ANG_W-1:0] THREE_HALF_PI_Q32 = 36'd20239556557;
    localparam logic [ANG_W-1:0] TWO_PI_Q32        = 36'd26986075409;

    // atan(2^-i), Q32 radians
    localparam logic [31:0] ATAN_Q32 [32] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175347, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512,
        32'd256,        32'd128,        32'd64,         32'd32,
        32'd16,         32'd8,          32'd4,          32'd2
    };

    // how the final angle is formed
    typedef enum logic [2:0] {
        DIR_Q1,
        DIR_Q2,
        DIR_Q3,
        DIR_Q4,
        DIR_ZERO,
        DIR_HALF_PI,
        DIR_PI,
        DIR_THREE_HALF_PI
    } t_dir_sel;

endpackage

`default_nettype wire

>>> rtl/direction_angle_full_circle_core.sv
// ----------------------------------------------------------------------------
// direction_angle_full_circle_core
// direction angle from a start point to an end point, 0 up to 2*pi, by a
// pipelined cordic in vectoring mode
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  input     i_valid, o_stall, i_from_x/y, i_to_x/y     in
//  output    o_valid, i_stall, o_direction              out
//
//  one point pair per cycle while o_stall is low; the pipeline is made of the
//  difference stage, fold stage, one cordic iteration per stage, the
//  quadrant map stage and the rounding stage
//  synchronous active-low reset clears all valid bits and the skid register
//  a stalled result moves into a skid register; o_stall is high while the
//  skid register holds a result, and the pipeline holds during that time
// ----------------------------------------------------------------------------
`default_nettype none

module direction_angle_full_circle_core
    import dafc_pkg::*;
#(
    parameter int COORD_BITS      = DEF_COORD_BITS,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0]      i_from_x,
    input  wire logic signed [COORD_BITS-1:0]      i_from_y,
    input  wire logic signed [COORD_BITS-1:0]      i_to_x,
    input  wire logic signed [COORD_BITS-1:0]      i_to_y,
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic [ANGLE_FRAC_BITS+2:0]        o_direction
);

    localparam int DW         = COORD_BITS + 1;
    localparam int GUARD_BITS = CORDIC_W - CORDIC_HEAD - COORD_BITS;
    localparam int OW         = ANGLE_FRAC_BITS + 3;
    localparam int SHIFT      = 32 - ANGLE_FRAC_BITS;
    localparam logic [ANG_W-1:0] ROUND_Q32 = ANG_W'(1) << (31 - ANGLE_FRAC_BITS);

    logic en;

    // difference stage
    logic               r_v0;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [DW-1:0] n_dx;
    logic signed [DW-1:0] n_dy;

    // cordic stage registers, index 0 is loaded by the fold stage
    logic                        r_cv   [CORDIC_STAGES+1];
    t_dir_sel                    r_csel [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0]  r_cx   [CORDIC_STAGES+1];
    logic signed [CORDIC_W-1:0]  r_cy   [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0]     r_cz   [CORDIC_STAGES+1];

    // fold stage
    t_dir_sel        n_sel;
    logic [DW-1:0]   n_ax;
    logic [DW-1:0]   n_ay;

    // map and rounding stages
    logic               r_mv;
    logic [ANG_W-1:0]   r_ang;
    logic [ANG_W-1:0]   n_zc;
    logic [ANG_W-1:0]   n_ang;
    logic               r_ov;
    logic [OW-1:0]      r_dir;
    logic [ANG_W-1:0]   n_rsum;

    // skid register
    logic               r_skid_vld;
    logic [OW-1:0]      r_skid_dir;

    assign en = !r_skid_vld;

    // ---------------- difference ----------------
    assign n_dx = $signed({i_to_x[COORD_BITS-1], i_to_x})
                - $signed({i_from_x[COORD_BITS-1], i_from_x});
    assign n_dy = $signed({i_to_y[COORD_BITS-1], i_to_y})
                - $signed({i_from_y[COORD_BITS-1], i_from_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
        if (en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // ---------------- fold into the first quadrant ----------------
    always_comb begin
        n_ax = r_dx[DW-1] ? $unsigned(-r_dx) : $unsigned(r_dx);
        n_ay = r_dy[DW-1] ? $unsigned(-r_dy) : $unsigned(r_dy);
        if (r_dx == '0) begin
            if (r_dy == '0) begin
                n_sel = DIR_ZERO;
            end else if (r_dy[DW-1]) begin
                n_sel = DIR_THREE_HALF_PI;
            end else begin
                n_sel = DIR_HALF_PI;
            end
        end else if (r_dy == '0) begin
            n_sel = r_dx[DW-1] ? DIR_PI : DIR_ZERO;
        end else if (!r_dx[DW-1]) begin
            n_sel = r_dy[DW-1] ? DIR_Q4 : DIR_Q1;
        end else begin
            n_sel = r_dy[DW-1] ? DIR_Q3 : DIR_Q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_v0;
        end
        if (en) begin
            r_csel[0] <= n_sel;
            r_cx[0]   <= $signed({{(CORDIC_W-DW){1'b0}}, n_ax} << GUARD_BITS);
            r_cy[0]   <= $signed({{(CORDIC_W-DW){1'b0}}, n_ay} << GUARD_BITS);
            r_cz[0]   <= '0;
        end
    end

    // ---------------- cordic iterations, one per stage ----------------
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [CORDIC_W-1:0] n_xs;
        logic signed [CORDIC_W-1:0] n_ys;
        logic signed [ANG_W-1:0]    n_atan;
        logic                       n_pos;

        assign n_xs   = r_cx[i] >>> i;
        assign n_ys   = r_cy[i] >>> i;
        assign n_atan = $signed({{(ANG_W-32){1'b0}}, ATAN_Q32[i]});
        assign n_pos  = !r_cy[i][CORDIC_W-1] && (r_cy[i] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
            if (en) begin
                r_csel[i+1] <= r_csel[i];
                if (n_pos) begin
                    r_cx[i+1] <= r_cx[i] + n_ys;
                    r_cy[i+1] <= r_cy[i] - n_xs;
                    r_cz[i+1] <= r_cz[i] + n_atan;
                end else begin
                    r_cx[i+1] <= r_cx[i] - n_ys;
                    r_cy[i+1] <= r_cy[i] + n_xs;
                    r_cz[i+1] <= r_cz[i] - n_atan;
                end
            end
        end
    end

    // ---------------- clamp and quadrant map ----------------
    always_comb begin
        if (r_cz[CORDIC_STAGES][ANG_W-1]) begin
            n_zc = '0;
        end else if ($unsigned(r_cz[CORDIC_STAGES]) > HALF_PI_Q32) begin
            n_zc = HALF_PI_Q32;
        end else begin
            n_zc = $unsigned(r_cz[CORDIC_STAGES]);
        end
        unique case (r_csel[CORDIC_STAGES])
            DIR_Q1:            n_ang = n_zc;
            DIR_Q2:            n_ang = PI_Q32 - n_zc;
            DIR_Q3:            n_ang = PI_Q32 + n_zc;
            DIR_Q4:            n_ang = TWO_PI_Q32 - n_zc;
            DIR_ZERO:          n_ang = '0;
            DIR_HALF_PI:       n_ang = HALF_PI_Q32;
            DIR_PI:            n_ang = PI_Q32;
            DIR_THREE_HALF_PI: n_ang = THREE_HALF_PI_Q32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= r_cv[CORDIC_STAGES];
        end
        if (en) begin
            r_ang <= n_ang;
        end
    end

    // ---------------- round to the output format ----------------
    assign n_rsum = r_ang + ROUND_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_mv;
        end
        if (en) begin
            r_dir <= n_rsum[SHIFT +: OW];
        end
    end

    // ---------------- output skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_ov && i_stall) begin
            r_skid_vld <= 1'b1;
        end
        if (!r_skid_vld) begin
            r_skid_dir <= r_dir;
        end
    end

    assign o_stall     = r_skid_vld;
    assign o_valid     = r_skid_vld || r_ov;
    assign o_direction = r_skid_vld ? r_skid_dir : r_dir;

endmodule

`default_nettype wire

>>> rtl/dafc_checker.sv
// ----------------------------------------------------------------------------
// dafc_checker
// port-level checks on the direction angle core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "direction_angle_full_circle_core_assert.svh"

module dafc_checker
    import dafc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [ANGLE_FRAC_BITS+2:0]  o_direction
);

    localparam int OW = ANGLE_FRAC_BITS + 3;
    localparam logic [ANG_W-1:0] MAX_SUM =
        TWO_PI_Q32 + (ANG_W'(1) << (31 - ANGLE_FRAC_BITS));
    localparam logic [OW-1:0] MAX_CODE = MAX_SUM[32-ANGLE_FRAC_BITS +: OW];

    // a stalled result stays offered and unchanged
    `DAFC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `DAFC_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_direction))

    // angle never passes the code of a full circle
    `DAFC_ASSERT(a_dir_range, i_clk, i_rst_n, o_valid |-> o_direction <= MAX_CODE)

    // input side only stalls after a result was held back
    `DAFC_ASSERT(a_stall_cause, i_clk, i_rst_n, $rose(o_stall) |-> $past(o_valid && i_stall))

    // reset empties the pipeline and the skid register
    `DAFC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind direction_angle_full_circle_core dafc_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_dafc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_direction (o_direction)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// direction angle core testbench
// sends point pairs through the valid/stall input channel, predicts each
// direction angle with a bit-exact cordic vectoring model and compares every
// result in order, with random idle bursts on the input and stall bursts on the output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import dafc_pkg::*;
();

    localparam int COORD_W    = DEF_COORD_BITS;
    localparam int FRAC_W     = DEF_ANGLE_FRAC_BITS;
    localparam int STAGES     = DEF_CORDIC_STAGES;
    localparam int DIR_W      = FRAC_W + 3;
    localparam int LATENCY    = STAGES + 4;
    localparam int GUARD      = 58 - COORD_W;
    localparam int N_ITEMS    = 950;
    localparam int CYCLE_LIMIT = 400000;

    // angles in Q32 radians
    localparam longint RAD90_Q32  = 64'd6746518852;
    localparam longint RAD180_Q32 = 64'd13493037705;
    localparam longint RAD270_Q32 = 64'd20239556557;
    localparam longint RAD360_Q32 = 64'd26986075409;

    // atan(2^-i), Q32 radians
    localparam longint ATAN_STEP_Q32 [32] = '{
        64'd3373259426, 64'd1991351318, 64'd1052175347, 64'd534100635,
        64'd268086748,  64'd134174063,  64'd67103403,   64'd33553749,
        64'd16777131,   64'd8388597,    64'd4194303,    64'd2097152,
        64'd1048576,    64'd524288,     64'd262144,     64'd131072,
        64'd65536,      64'd32768,      64'd16384,      64'd8192,
        64'd4096,       64'd2048,       64'd1024,       64'd512,
        64'd256,        64'd128,        64'd64,         64'd32,
        64'd16,         64'd8,          64'd4,          64'd2
    };

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        t_coord fx;
        t_coord fy;
        t_coord tx;
        t_coord ty;
        bit     drain;
    } t_point_pair;

    localparam t_coord C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_coord C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_coord            i_from_x = '0;
    t_coord            i_from_y = '0;
    t_coord            i_to_x = '0;
    t_coord            i_to_y = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [DIR_W-1:0]  o_direction;

    t_point_pair       pending_pairs [$];
    logic [DIR_W-1:0]  expected_dirs [$];

    int n_directed;
    int n_sent;
    int n_checked;
    int n_errors;
    int n_cycles;
    int n_idle_bursts;
    int n_stall_bursts;
    int n_drains;
    int gap_left;
    int stall_left;
    t_point_pair next_pair;

    direction_angle_full_circle_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_from_x    (i_from_x),
        .i_from_y    (i_from_y),
        .i_to_x      (i_to_x),
        .i_to_y      (i_to_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_direction (o_direction)
    );

    always #5 i_clk = ~i_clk;

    // direction of (to - from), 0 up to 2*pi, rounded to the output code
    function automatic logic [DIR_W-1:0] predict_direction(input t_coord fx, input t_coord fy,
                                                           input t_coord tx, input t_coord ty);
        longint dx, dy, ax, ay, x, y, z, xs, ys, ang, code;
        dx = longint'(tx) - longint'(fx);
        dy = longint'(ty) - longint'(fy);
        if (dx == 0) begin
            if (dy == 0)
                ang = 0;
            else
                ang = (dy > 0) ? RAD90_Q32 : RAD270_Q32;
        end else if (dy == 0) begin
            ang = (dx > 0) ? 0 : RAD180_Q32;
        end else begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            x = ax <<< GUARD;
            y = ay <<< GUARD;
            z = 0;
            for (int i = 0; i < STAGES && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP_Q32[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP_Q32[i];
                end
            end
            // leftover iteration error may step outside the first quadrant
            if (z < 0)
                z = 0;
            if (z > RAD90_Q32)
                z = RAD90_Q32;
            if (dx > 0)
                ang = (dy > 0) ? z : RAD360_Q32 - z;
            else
                ang = (dy > 0) ? RAD180_Q32 - z : RAD180_Q32 + z;
        end
        code = (ang + (longint'(1) <<< (31 - FRAC_W))) >>> (32 - FRAC_W);
        return code[DIR_W-1:0];
    endfunction

    task automatic add_pair(input t_coord fx, input t_coord fy, input t_coord tx,
                            input t_coord ty, input bit drain);
        t_point_pair p;
        p.fx = fx;
        p.fy = fy;
        p.tx = tx;
        p.ty = ty;
        p.drain = drain;
        if (drain)
            n_drains++;
        pending_pairs.push_back(p);
    endtask

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    function automatic t_coord edge_coord();
        case ($urandom_range(5))
            0: return C_MIN;
            1: return C_MAX;
            2: return t_coord'(0);
            3: return t_coord'(-1);
            4: return t_coord'(1);
            default: return rand_coord();
        endcase
    endfunction

    // idle share in percent: phases with none, some and heavy idling, none at the tail
    function automatic int idle_percent(input int done);
        if (pending_pairs.size() < 120)
            return 0;
        case ((done / 150) % 3)
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_dirs.push_back(predict_direction(i_from_x, i_from_y, i_to_x, i_to_y));
                n_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0 &&
                             !(pending_pairs[0].drain && expected_dirs.size() != 0)) begin
                    if ($urandom_range(99) < idle_percent(n_sent)) begin
                        gap_left = $urandom_range(15, 1) - 1;
                        n_idle_bursts++;
                        i_valid <= 1'b0;
                    end else begin
                        next_pair = pending_pairs.pop_front();
                        i_valid  <= 1'b1;
                        i_from_x <= next_pair.fx;
                        i_from_y <= next_pair.fy;
                        i_to_x   <= next_pair.tx;
                        i_to_y   <= next_pair.ty;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_dirs.size() == 0) begin
                    $display("%0t: unexpected direction transfer, expected none, actual %0d",
                             $time, o_direction);
                    n_errors++;
                end else begin
                    logic [DIR_W-1:0] want;
                    want = expected_dirs.pop_front();
                    if (o_direction !== want) begin
                        $display("%0t: direction mismatch, expected %0d, actual %0d",
                                 $time, want, o_direction);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(99) < idle_percent(n_checked + 75)) begin
                stall_left = $urandom_range(15, 1) - 1;
                n_stall_bursts++;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d directions still expected", $time, expected_dirs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_coord fx, fy, d;
        int kind;

        // coincident points
        add_pair(0, 0, 0, 0, 0);
        add_pair(C_MIN, C_MIN, C_MIN, C_MIN, 0);
        add_pair(C_MAX, C_MAX, C_MAX, C_MAX, 0);
        // the four axis directions
        add_pair(0, 0, 5, 0, 0);
        add_pair(0, 0, 0, 7, 0);
        add_pair(0, 0, -3, 0, 0);
        add_pair(0, 0, 0, -9, 0);
        // widest differences, beyond the coordinate range
        add_pair(C_MIN, 0, C_MAX, 0, 0);
        add_pair(C_MAX, 0, C_MIN, 0, 0);
        add_pair(0, C_MIN, 0, C_MAX, 0);
        add_pair(0, C_MAX, 0, C_MIN, 0);
        // extreme diagonals in each quadrant
        add_pair(C_MIN, C_MIN, C_MAX, C_MAX, 0);
        add_pair(C_MAX, C_MIN, C_MIN, C_MAX, 0);
        add_pair(C_MAX, C_MAX, C_MIN, C_MIN, 0);
        add_pair(C_MIN, C_MAX, C_MAX, C_MIN, 0);
        // just below full circle, rounds up to the 2*pi code
        add_pair(C_MIN, 0, C_MAX, -1, 0);
        // steep vector near pi/2 where the residual gets clamped
        add_pair(0, C_MIN, 1, C_MAX, 0);
        // unit diagonals
        add_pair(0, 0, 1, 1, 0);
        add_pair(0, 0, -1, 1, 0);
        add_pair(0, 0, -1, -1, 0);
        add_pair(0, 0, 1, -1, 0);
        // tiny angles next to the axes
        add_pair(C_MIN, 0, C_MAX, 1, 0);
        add_pair(C_MAX, 0, C_MIN, -1, 0);
        add_pair(0, C_MAX, -1, C_MIN, 0);
        add_pair(-1, -1, t_coord'(24'h555555), t_coord'(24'haaaaaa), 1);
        n_directed = pending_pairs.size();

        while (pending_pairs.size() < N_ITEMS) begin
            fx = rand_coord();
            fy = rand_coord();
            kind = $urandom_range(99);
            if (kind < 35) begin
                add_pair(fx, fy, rand_coord(), rand_coord(), $urandom_range(99) == 0);
            end else if (kind < 60) begin
                add_pair(fx, fy, fx + t_coord'($urandom_range(128) - 64),
                         fy + t_coord'($urandom_range(128) - 64), 0);
            end else if (kind < 70) begin
                if ($urandom_range(1))
                    add_pair(fx, fy, fx, rand_coord(), 0);
                else
                    add_pair(fx, fy, rand_coord(), fy, 0);
            end else if (kind < 75) begin
                add_pair(fx, fy, fx, fy, 0);
            end else if (kind < 85) begin
                d = t_coord'($urandom_range(4000000, 1));
                add_pair(fx, fy, $urandom_range(1) ? fx + d : fx - d,
                         $urandom_range(1) ? fy + d : fy - d, 0);
            end else begin
                add_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(), 0);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || i_valid || expected_dirs.size() != 0)
            @(negedge i_clk);
        repeat (2 * LATENCY + 10) @(posedge i_clk);

        $display("covered %0d point pairs (%0d directed, %0d random), %0d directions compared",
                 n_sent, n_directed, n_sent - n_directed, n_checked);
        $display("%0d idle bursts, %0d stall bursts, %0d full drains of the pipeline",
                 n_idle_bursts, n_stall_bursts, n_drains);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors", n_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/dafc_pkg.sv
rtl/direction_angle_full_circle_core.sv
rtl/dafc_checker.sv
tb/testbench.sv
